// ----- rtl/core/modular_exponentiation_assert.svh -----
// Assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH
`ifndef SYNTH
`define MEXP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define MEXP_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MEXP_ASSERT(label, clk, rst, prop)
`define MEXP_ASSERT_NR(label, clk, prop)
`endif
`endif

// ----- rtl/core/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;
  localparam int DEFAULT_DATA_WIDTH = 32;
  localparam int RESULT_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENC_EXP = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEC_EXP = 2'd2;
  localparam logic REQ_ENCRYPT = 1'b0;
endpackage

// ----- rtl/core/mexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"
module mexp_mulmod import mexp_pkg::*; #(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  input  logic [DATA_WIDTH-1:0] m,
  output logic                  busy,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] prod
);
  localparam int CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] opa, opb, md, acc;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH:0]   dbl, dbl_r, sum;
  logic [DATA_WIDTH-1:0] acc_next;

  // double then conditionally add, each reduced by one compare-subtract
  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, md}) ? dbl - {1'b0, md} : dbl;
    sum   = dbl_r + (opb[DATA_WIDTH-1] ? {1'b0, opa} : '0);
    if (sum >= {1'b0, md}) sum = sum - {1'b0, md};
    acc_next = sum[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      opa  <= a;
      opb  <= b;
      md   <= m;
      acc  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      acc <= acc_next;
      opb <= opb << 1;
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DATA_WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign prod = acc;

  `MEXP_ASSERT(a_done_after_busy, clk, rst, done |-> $past(busy))
  `MEXP_ASSERT(a_acc_below_mod, clk, rst, (busy && !$past(start)) |-> acc < md)
  `MEXP_ASSERT(a_no_start_busy, clk, rst, busy |-> !start)
endmodule

// ----- rtl/core/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply: result = value^exponent mod modulus.
// ----------------------------------------------------------------------------
// One request at a time. The base is first reduced modulo the modulus by a
// restoring shift-subtract. Then, for each exponent bit up to the highest set
// one, a multiply (when the bit is set) and a square run on the single shared
// bit-serial mod-multiplier. Range errors and a zero modulus skip both steps
// and go straight to the output register. The result waits in that output
// register while out_stall holds. A new request is taken once the result is
// delivered.
`include "modular_exponentiation_assert.svh"
module modular_exponentiation import mexp_pkg::*; #(
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       req_type,
  input  logic [31:0]                value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [RESULT_WIDTH-1:0]    result,
  output logic                       range_error
);
  localparam int CW = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_MUL, S_MWAIT, S_SQ, S_SWAIT, S_OUT} state_t;

  logic [DATA_WIDTH-1:0] modulus, enc_exp, dec_exp;
  state_t                state;
  logic [DATA_WIDTH-1:0] base, acc, expo, vin;
  logic [DATA_WIDTH:0]   rem, rem_sh, rem_next;
  logic [CW-1:0]         cnt;
  logic                  mm_start, mm_busy, mm_done;
  logic [DATA_WIDTH-1:0] mm_a, mm_b, mm_prod;
  logic [DATA_WIDTH-1:0] vext;

  assign vext = DATA_WIDTH'(value);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= DATA_WIDTH'(2);
      enc_exp <= DATA_WIDTH'(1);
      dec_exp <= DATA_WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODULUS: modulus <= cfg_data;
        REG_ENC_EXP: enc_exp <= cfg_data;
        REG_DEC_EXP: dec_exp <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign rem_sh   = {rem[DATA_WIDTH-1:0], vin[DATA_WIDTH-1]};
  assign rem_next = (rem_sh >= {1'b0, modulus}) ? rem_sh - {1'b0, modulus} : rem_sh;

  always_comb begin
    mm_start = 1'b0;
    mm_a = acc;
    mm_b = base;
    // issue the multiply only for a set exponent bit
    if (state == S_MUL && expo[0]) mm_start = 1'b1;
    if (state == S_SQ) begin
      mm_start = 1'b1;
      mm_a = base;
    end
  end

  mexp_mulmod #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .m(modulus),
    .busy(mm_busy), .done(mm_done), .prod(mm_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          range_error <= 1'b0;
          result      <= '0;
          vin  <= vext;
          expo <= (req_type == REQ_ENCRYPT) ? enc_exp : dec_exp;
          acc  <= (modulus == DATA_WIDTH'(1)) ? '0 : DATA_WIDTH'(1);
          rem  <= '0;
          cnt  <= '0;
          if (modulus == '0) begin
            range_error <= (req_type == REQ_ENCRYPT);
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end else if (req_type == REQ_ENCRYPT && (vext == '0 || vext >= modulus)) begin
            range_error <= 1'b1;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end else begin
            state <= S_RED;
          end
        end
        S_RED: begin
          // restoring reduction of the base, one bit a cycle
          rem <= rem_next;
          vin <= vin << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(DATA_WIDTH - 1)) begin
            base  <= rem_next[DATA_WIDTH-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (expo == '0) begin
            result    <= RESULT_WIDTH'(acc);
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= expo[0] ? S_MWAIT : S_SQ;
          end
          cnt <= '0;
        end
        S_MWAIT: if (mm_done) begin
          acc   <= mm_prod;
          state <= S_SQ;
        end
        S_SQ: state <= S_SWAIT;
        S_SWAIT: if (mm_done) begin
          base  <= mm_prod;
          expo  <= expo >> 1;
          state <= S_MUL;
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MEXP_ASSERT(a_out_in_outstate, clk, rst, out_valid |-> state == S_OUT)
  `MEXP_ASSERT(a_mul_only_busy, clk, rst, (state == S_MWAIT || state == S_SWAIT) |-> (mm_busy || mm_done || $past(mm_start)))
  `MEXP_ASSERT(a_err_zero_result, clk, rst, (out_valid && range_error) |-> result == '0)
endmodule
